/* rtl/fcw_pkg.sv */
// ----------------------------------------------------------------------------
// fcw_pkg: shared types and constants for the FAT12 cluster chain walker
// Holds the item commands, register indexes, controller states and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package fcw_pkg;

  localparam int CLUSTER_W = 12;
  localparam int ADDR_W    = 13;
  localparam int BYTE_W    = 8;
  localparam int LBA_W     = 32;
  localparam int SPC_W     = 8;
  localparam int PROD_W    = CLUSTER_W + SPC_W;

  localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 12'h002;
  localparam logic [CLUSTER_W-1:0] END_MARK           = 12'hFF8;
  localparam logic [LBA_W-1:0]     LBA_RESET          = 32'd33;
  localparam logic [SPC_W-1:0]     SPC_RESET          = 8'd1;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_START   = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_DATA_LBA = 1'b0,
    CFG_SECTORS  = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take_item;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_steps;
  } dp_status_t;

endpackage

/* rtl/fat12_cluster_chain_walker.sv */
// Start and advance transactions: accept, then the even/odd table bank read
// returns and the result register loads once it is free. Load transactions
// give no result.
// One step in flight at a time, set by the table read feeding the chain state.
// Reset clears controller and chain state and sets the configuration to its
// defaults; the table is not cleared and holds whatever was loaded.
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker: FAT12 cluster chain follower
// Holds a copy of the allocation table and reports the sector range and
// next entry for each cluster of a chain.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  fcw_pkg::cfg_reg_t cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  fcw_pkg::cmd_t     cmd,
  input  logic [12:0]       table_addr,
  input  logic [7:0]        table_byte,
  input  logic [11:0]       first_cluster,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       sector_addr,
  output logic [7:0]        sector_count,
  output logic [11:0]       cluster_now,
  output logic [11:0]       cluster_next,
  output logic              last,
  output logic              bad
);

  import fcw_pkg::*;

  dp_cmd_t    ctl;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  fcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  fcw_datapath #(.TABLE_BYTES(TABLE_BYTES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .table_addr    (table_addr),
    .table_byte    (table_byte),
    .first_cluster (first_cluster),
    .sector_addr   (sector_addr),
    .sector_count  (sector_count),
    .cluster_now   (cluster_now),
    .cluster_next  (cluster_next),
    .last          (last),
    .bad           (bad)
  );

endmodule

/* rtl/fcw_table_ram.sv */
// ----------------------------------------------------------------------------
// fcw_table_ram: single-port table bank
// One address per cycle, written or read; the read data is registered and
// holds until the next read.
// ----------------------------------------------------------------------------
module fcw_table_ram #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* rtl/fcw_datapath.sv */
// ----------------------------------------------------------------------------
// fcw_datapath: table banks, chain state and result registers
// The table is split into even and odd byte banks so that both bytes of an
// entry come back from one read.
// ----------------------------------------------------------------------------
module fcw_datapath #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic                clk,
  input  logic                rst,
  input  fcw_pkg::dp_cmd_t    ctl,
  output fcw_pkg::dp_status_t sts,
  input  logic                cfg_valid,
  input  fcw_pkg::cfg_reg_t   cfg_index,
  input  logic [31:0]         cfg_data,
  input  fcw_pkg::cmd_t       cmd,
  input  logic [12:0]         table_addr,
  input  logic [7:0]          table_byte,
  input  logic [11:0]         first_cluster,
  output logic [31:0]         sector_addr,
  output logic [7:0]          sector_count,
  output logic [11:0]         cluster_now,
  output logic [11:0]         cluster_next,
  output logic                last,
  output logic                bad
);

  import fcw_pkg::*;

  localparam int EVEN_DEPTH = (TABLE_BYTES + 1) / 2;
  localparam int ODD_DEPTH  = TABLE_BYTES / 2;
  localparam int EVEN_AW    = $clog2(EVEN_DEPTH);
  localparam int ODD_AW     = $clog2(ODD_DEPTH);
  localparam logic [ADDR_W:0] TABLE_LIM = (ADDR_W + 1)'(TABLE_BYTES);

  // configuration
  logic [LBA_W-1:0] data_region_lba;
  logic [SPC_W-1:0] sectors_per_cluster;

  // chain state
  logic [CLUSTER_W-1:0] current_cluster;
  logic                 chain_active;

  // item registers
  logic [CLUSTER_W-1:0] item_cluster;
  logic                 item_bad;
  logic                 item_lo_oob;
  logic                 item_hi_oob;
  logic                 item_off_odd;
  logic [PROD_W-1:0]    item_prod;

  logic                 is_step;
  logic                 is_load;
  logic                 load_in_range;
  logic [CLUSTER_W-1:0] sel_cluster;
  logic [CLUSTER_W-1:0] sel_minus2;
  logic [ADDR_W-1:0]    offset;
  logic [ADDR_W-1:0]    offset_plus;
  logic [PROD_W-1:0]    prod;

  logic                 even_en, even_we, odd_en, odd_we;
  logic [EVEN_AW-1:0]   even_addr;
  logic [ODD_AW-1:0]    odd_addr;
  logic [7:0]           even_rdata, odd_rdata;

  logic [7:0]           lo_byte, hi_byte;
  logic [15:0]          pair;
  logic [CLUSTER_W-1:0] next_entry;

  assign is_step = (cmd == CMD_START) || (cmd == CMD_ADVANCE);
  assign is_load = (cmd == CMD_LOAD);
  assign load_in_range = ({1'b0, table_addr} < TABLE_LIM);
  assign sts.item_steps = is_step;

  assign sel_cluster = (cmd == CMD_START) ? first_cluster : current_cluster;
  assign sel_minus2  = sel_cluster - FIRST_DATA_CLUSTER;
  assign prod        = PROD_W'(sel_minus2) * PROD_W'(sectors_per_cluster);

  // byte offset of the entry: cluster * 3 / 2
  assign offset      = {1'b0, sel_cluster} + {2'b00, sel_cluster[CLUSTER_W-1:1]};
  assign offset_plus = offset + 13'd1;

  always_comb begin
    even_en = 1'b0;
    even_we = 1'b0;
    odd_en  = 1'b0;
    odd_we  = 1'b0;
    even_addr = offset_plus[EVEN_AW:1];
    odd_addr  = offset[ODD_AW:1];
    if (ctl.take_item) begin
      if (is_load) begin
        even_addr = table_addr[EVEN_AW:1];
        odd_addr  = table_addr[ODD_AW:1];
        even_en   = load_in_range && !table_addr[0];
        even_we   = load_in_range && !table_addr[0];
        odd_en    = load_in_range && table_addr[0];
        odd_we    = load_in_range && table_addr[0];
      end else if (is_step) begin
        even_en = 1'b1;
        odd_en  = 1'b1;
      end
    end
  end

  fcw_table_ram #(.DEPTH(EVEN_DEPTH)) u_even (
    .clk   (clk),
    .en    (even_en),
    .we    (even_we),
    .addr  (even_addr),
    .wdata (table_byte),
    .rdata (even_rdata)
  );

  fcw_table_ram #(.DEPTH(ODD_DEPTH)) u_odd (
    .clk   (clk),
    .en    (odd_en),
    .we    (odd_we),
    .addr  (odd_addr),
    .wdata (table_byte),
    .rdata (odd_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      data_region_lba     <= LBA_RESET;
      sectors_per_cluster <= SPC_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DATA_LBA: data_region_lba     <= cfg_data;
        CFG_SECTORS:  sectors_per_cluster <= cfg_data[SPC_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_item && is_step) begin
      item_cluster <= sel_cluster;
      item_bad     <= (sel_cluster < FIRST_DATA_CLUSTER)
                      || ((cmd == CMD_ADVANCE) && !chain_active);
      item_lo_oob  <= ({1'b0, offset} >= TABLE_LIM);
      item_hi_oob  <= ({1'b0, offset_plus} >= TABLE_LIM);
      item_off_odd <= offset[0];
      item_prod    <= prod;
    end
  end

  // bytes beyond the store read as zero
  assign lo_byte = item_lo_oob ? 8'h00 : (item_off_odd ? odd_rdata : even_rdata);
  assign hi_byte = item_hi_oob ? 8'h00 : (item_off_odd ? even_rdata : odd_rdata);
  assign pair    = {hi_byte, lo_byte};
  assign next_entry = item_cluster[0] ? pair[15:4] : pair[11:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      current_cluster <= '0;
      chain_active    <= 1'b0;
    end else if (ctl.finish) begin
      if (item_bad) begin
        current_cluster <= item_cluster;
        chain_active    <= 1'b0;
      end else begin
        current_cluster <= next_entry;
        chain_active    <= (next_entry < END_MARK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      cluster_now <= item_cluster;
      bad         <= item_bad;
      if (item_bad) begin
        sector_addr  <= '0;
        sector_count <= '0;
        cluster_next <= '0;
        last         <= 1'b0;
      end else begin
        sector_addr  <= data_region_lba + LBA_W'(item_prod);
        sector_count <= sectors_per_cluster;
        cluster_next <= next_entry;
        last         <= (next_entry >= END_MARK);
      end
    end
  end

endmodule

/* rtl/fcw_ctrl.sv */
// ----------------------------------------------------------------------------
// fcw_ctrl: handshake and sequencing controller
// Takes items in idle, waits in busy for the table read and loads the
// result register when it is free.
// ----------------------------------------------------------------------------
module fcw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output fcw_pkg::dp_cmd_t    ctl,
  input  fcw_pkg::dp_status_t sts
);

  import fcw_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    ctl.take_item = 1'b0;
    ctl.finish    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctl.take_item = in_valid;
        if (in_valid && sts.item_steps) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        // result register free or emptied this cycle
        if (!out_valid || out_ready) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (ctl.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

/* tb/fat12_cluster_chain_walker_tb.sv */
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_tb: self-checking bench for the FAT12 walker
// A directed list covers reset state, bad clusters, chain ends and the table
// extremes. Random chains follow under several register settings.
// Each result is checked against a fixed value or an in-bench model of the table and chain.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcw_pkg::*;

  localparam int ITEM_TARGET = 1800;
  localparam int QUIET_TAIL  = 150;
  localparam int N_PHASES    = 5;
  localparam int N_ROWS      = 21;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    logic [31:0] sector_addr;
    logic [7:0]  sector_count;
    logic [11:0] cluster_now;
    logic [11:0] cluster_next;
    logic        last;
    logic        bad;
  } cluster_res_t;

  typedef struct packed {
    cmd_t         op;
    logic [12:0]  addr;
    logic [7:0]   data;
    logic [11:0]  clus;
    logic         fixed;
    cluster_res_t want;
  } stim_row_t;

  localparam cluster_res_t NO_RES = '0;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_t    cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  cmd_t        cmd;
  logic [12:0] table_addr;
  logic [7:0]  table_byte;
  logic [11:0] first_cluster;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] sector_addr;
  logic [7:0]  sector_count;
  logic [11:0] cluster_now;
  logic [11:0] cluster_next;
  logic        last;
  logic        bad;

  // shadow of the allocation table and the chain position
  logic [7:0]   fat_copy [8192];
  bit           fat_seen [8192];
  logic [11:0]  chain_cluster;
  bit           chain_live;
  logic [31:0]  data_lba;
  logic [7:0]   spc_now;
  cluster_res_t pending_results [$];

  stim_row_t directed_rows [N_ROWS];
  int        n_errors = 0;
  int        n_items = 0;
  bit        quiet = 1'b0;
  int        in_idle_pct = 30;
  int        out_idle_pct = 30;
  int        ready_hold = 0;

  fat12_cluster_chain_walker DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .table_addr   (table_addr),
    .table_byte   (table_byte),
    .first_cluster(first_cluster),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sector_addr  (sector_addr),
    .sector_count (sector_count),
    .cluster_now  (cluster_now),
    .cluster_next (cluster_next),
    .last         (last),
    .bad          (bad)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[fat12_cluster_chain_walker] ERROR");
    $finish;
  end

  function automatic cluster_res_t res_of(logic [31:0] sa, logic [7:0] sc, logic [11:0] now,
                                          logic [11:0] nxt, logic lst, logic bd);
    return {sa, sc, now, nxt, lst, bd};
  endfunction

  // sector range and table entry of one cluster; moves the chain on
  function automatic cluster_res_t describe_cluster(logic [11:0] cl);
    int           off;
    logic [15:0]  pair;
    logic [11:0]  nxt;
    cluster_res_t r;
    r = '0;
    r.cluster_now = cl;
    if (cl < FIRST_DATA_CLUSTER) begin
      r.bad = 1'b1;
      chain_live = 1'b0;
      return r;
    end
    off = (int'(cl) * 3) / 2;
    pair = {fat_copy[off + 1], fat_copy[off]};
    nxt = cl[0] ? pair[15:4] : pair[11:0];
    r.sector_addr  = data_lba + (32'(cl) - 32'd2) * 32'(spc_now);
    r.sector_count = spc_now;
    r.cluster_next = nxt;
    r.last         = (nxt >= END_MARK);
    chain_cluster  = nxt;
    chain_live     = !r.last;
    return r;
  endfunction

  function automatic bit predict_walk(cmd_t op, logic [12:0] a, logic [7:0] d,
                                      logic [11:0] fc, output cluster_res_t r);
    r = '0;
    case (op)
      CMD_LOAD: begin
        fat_copy[a] = d;
        fat_seen[a] = 1'b1;
        return 1'b0;
      end
      CMD_START: begin
        chain_cluster = fc;
        r = describe_cluster(fc);
        return 1'b1;
      end
      CMD_ADVANCE: begin
        if (chain_live) begin
          r = describe_cluster(chain_cluster);
        end else begin
          r.cluster_now = chain_cluster;
          r.bad = 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 35;
      default: return 70;
    endcase
  endfunction

  function automatic logic [11:0] random_link();
    case ($urandom_range(0, 9))
      0, 1, 2: return END_MARK + 12'($urandom_range(0, 7));
      3: return 12'($urandom_range(0, 1));
      default: return 12'($urandom_range(2, 4095));
    endcase
  endfunction

  // some chains stay in a small corner so that entries share bytes
  function automatic logic [11:0] pick_cluster();
    if ($urandom_range(0, 4) == 0) return 12'($urandom_range(2, 40));
    return 12'($urandom_range(2, 4095));
  endfunction

  task automatic send_item(cmd_t op, logic [12:0] a, logic [7:0] d, logic [11:0] fc,
                           logic fixed, cluster_res_t want);
    cluster_res_t r;
    if (!quiet && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= op;
    table_addr    <= a;
    table_byte    <= d;
    first_cluster <= fc;
    do @(posedge clk); while (!in_ready);
    if (predict_walk(op, a, d, fc, r)) pending_results.push_back(fixed ? want : r);
    if (op != CMD_UNUSED) n_items++;
  endtask

  task automatic load_byte(logic [12:0] a, logic [7:0] d);
    send_item(CMD_LOAD, a, d, 12'($urandom), 1'b0, NO_RES);
  endtask

  // read-modify-write of the two bytes, keeping the neighbour's nibble
  task automatic write_entry(logic [11:0] cl, logic [11:0] v);
    int         off;
    logic [3:0] kept;
    off = (int'(cl) * 3) / 2;
    if (cl[0]) begin
      kept = fat_seen[off] ? fat_copy[off][3:0] : 4'($urandom);
      load_byte(13'(off), {v[3:0], kept});
      load_byte(13'(off + 1), v[11:4]);
    end else begin
      load_byte(13'(off), v[7:0]);
      kept = fat_seen[off + 1] ? fat_copy[off + 1][7:4] : 4'($urandom);
      load_byte(13'(off + 1), {kept, v[11:8]});
    end
  endtask

  // loads a random entry for a data cluster whose two bytes were not both loaded
  task automatic make_readable(logic [11:0] cl);
    int off;
    off = (int'(cl) * 3) / 2;
    if (cl >= FIRST_DATA_CLUSTER && !(fat_seen[off] && fat_seen[off + 1]))
      write_entry(cl, random_link());
  endtask

  task automatic start_chain(logic [11:0] fc);
    make_readable(fc);
    send_item(CMD_START, 13'($urandom), 8'($urandom), fc, 1'b0, NO_RES);
  endtask

  task automatic advance_chain();
    if (chain_live) make_readable(chain_cluster);
    send_item(CMD_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom), 1'b0, NO_RES);
  endtask

  // result side: check each transaction, then pick the next ready level
  always @(posedge clk) begin
    cluster_res_t got;
    cluster_res_t want;
    if (!rst && out_valid && out_ready) begin
      got = {sector_addr, sector_count, cluster_now, cluster_next, last, bad};
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("%0t: unexpected result, cluster_now=%h", $realtime, cluster_now);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display({"%0t: mismatch want addr=%h cnt=%0d now=%h next=%h last=%b bad=%b",
                      " got addr=%h cnt=%0d now=%h next=%h last=%b bad=%b"}, $realtime,
                     want.sector_addr, want.sector_count, want.cluster_now,
                     want.cluster_next, want.last, want.bad,
                     got.sector_addr, got.sector_count, got.cluster_now,
                     got.cluster_next, got.last, got.bad);
        end
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else if (!quiet && $urandom_range(99) < out_idle_pct) begin
      out_ready <= 1'b0;
      ready_hold = $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    logic [11:0] links [8];
    int          len;
    logic [31:0] lba_set;
    logic [7:0]  spc_set;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_DATA_LBA;
    cfg_data      = '0;
    in_valid      = 1'b0;
    cmd           = CMD_LOAD;
    table_addr    = '0;
    table_byte    = '0;
    first_cluster = '0;
    data_lba      = LBA_RESET;
    spc_now       = SPC_RESET;
    chain_cluster = '0;
    chain_live    = 1'b0;

    // clusters 2 -> 3 -> end; 4094 -> 4095 (end) and 4095 -> 0
    directed_rows = '{
      '{CMD_ADVANCE, 13'd0,    8'h00, 12'h000, 1'b1, res_of(0, 0, 12'h000, 12'h000, 0, 1)},
      '{CMD_START,   13'd0,    8'h00, 12'h000, 1'b1, res_of(0, 0, 12'h000, 12'h000, 0, 1)},
      '{CMD_START,   13'd0,    8'h00, 12'h001, 1'b1, res_of(0, 0, 12'h001, 12'h000, 0, 1)},
      '{CMD_ADVANCE, 13'd0,    8'h00, 12'h000, 1'b1, res_of(0, 0, 12'h001, 12'h000, 0, 1)},
      '{CMD_UNUSED,  13'h1FFF, 8'hFF, 12'hFFF, 1'b0, NO_RES},
      '{CMD_LOAD,    13'd0,    8'h55, 12'hFFF, 1'b0, NO_RES},
      '{CMD_LOAD,    13'h1FFF, 8'hFF, 12'h000, 1'b0, NO_RES},
      '{CMD_LOAD,    13'h1FFE, 8'h00, 12'h000, 1'b0, NO_RES},
      '{CMD_LOAD,    13'd3,    8'h03, 12'h000, 1'b0, NO_RES},
      '{CMD_LOAD,    13'd4,    8'hF0, 12'h000, 1'b0, NO_RES},
      '{CMD_LOAD,    13'd5,    8'hFF, 12'h000, 1'b0, NO_RES},
      '{CMD_START,   13'd0,    8'h00, 12'h002, 1'b1, res_of(33, 1, 12'h002, 12'h003, 0, 0)},
      '{CMD_ADVANCE, 13'd0,    8'h00, 12'h000, 1'b1, res_of(34, 1, 12'h003, 12'hFFF, 1, 0)},
      '{CMD_ADVANCE, 13'd0,    8'h00, 12'h000, 1'b1, res_of(0, 0, 12'hFFF, 12'h000, 0, 1)},
      '{CMD_LOAD,    13'd6141, 8'hFF, 12'h000, 1'b0, NO_RES},
      '{CMD_LOAD,    13'd6142, 8'h0F, 12'h000, 1'b0, NO_RES},
      '{CMD_LOAD,    13'd6143, 8'h00, 12'h000, 1'b0, NO_RES},
      '{CMD_START,   13'd0,    8'h00, 12'hFFE, 1'b1, res_of(4125, 1, 12'hFFE, 12'hFFF, 1, 0)},
      '{CMD_START,   13'd0,    8'h00, 12'hFFF, 1'b1, res_of(4126, 1, 12'hFFF, 12'h000, 0, 0)},
      '{CMD_ADVANCE, 13'd0,    8'h00, 12'h000, 1'b1, res_of(0, 0, 12'h000, 12'h000, 0, 1)},
      '{CMD_START,   13'd0,    8'h00, 12'h003, 1'b0, NO_RES}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                directed_rows[i].clus, directed_rows[i].fixed, directed_rows[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // registers change only once the walker has gone quiet
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      case (ph)
        0: begin
          lba_set = '1;
          spc_set = 8'd128;
        end
        1: begin
          lba_set = '0;
          spc_set = 8'd1;
        end
        3: begin
          lba_set = 32'hFFFF_F000 | 32'($urandom_range(0, 4095));
          spc_set = 8'($urandom_range(1, 128));
        end
        default: begin
          lba_set = $urandom;
          spc_set = 8'($urandom_range(1, 128));
        end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= CFG_SECTORS;
      cfg_data  <= {24'($urandom), spc_set};
      do @(posedge clk); while (!cfg_ready);
      spc_now = spc_set;
      cfg_index <= CFG_DATA_LBA;
      cfg_data  <= lba_set;
      do @(posedge clk); while (!cfg_ready);
      data_lba = lba_set;
      cfg_valid <= 1'b0;

      while (n_items < ITEM_TARGET * (ph + 1) / N_PHASES) begin
        quiet = (n_items >= ITEM_TARGET - QUIET_TAIL);
        in_idle_pct  = idle_pct();
        out_idle_pct = idle_pct();
        if ($urandom_range(0, 6) == 0) begin
          case ($urandom_range(0, 3))
            0: load_byte(13'($urandom), 8'($urandom));
            1: start_chain(12'($urandom));
            2: advance_chain();
            default: send_item(CMD_UNUSED, 13'($urandom), 8'($urandom), 12'($urandom),
                               1'b0, NO_RES);
          endcase
        end else begin
          len = $urandom_range(1, 8);
          foreach (links[k]) links[k] = pick_cluster();
          for (int k = 0; k < len - 1; k++) write_entry(links[k], links[k + 1]);
          write_entry(links[len - 1], random_link());
          start_chain(links[0]);
          // walk to the end and sometimes past it
          repeat (len - 1 + $urandom_range(0, 2)) advance_chain();
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("[fat12_cluster_chain_walker] OK");
    end else begin
      $display("[fat12_cluster_chain_walker] ERROR");
    end
    $finish;
  end

endmodule

/* fat12_cluster_chain_walker.f */
rtl/fcw_pkg.sv
rtl/fcw_table_ram.sv
rtl/fcw_datapath.sv
rtl/fcw_ctrl.sv
rtl/fat12_cluster_chain_walker.sv
tb/fat12_cluster_chain_walker_tb.sv
